// File: rtl/core/crc_pkg.sv
`default_nettype none

package crc_pkg;

    // Fixed-point and reset constants
    localparam int unsigned FP_W        = 17;
    localparam logic [FP_W-1:0] FP_ONE  = 17'd65536;
    localparam logic [31:0] RESET_MAX   = 32'd100000000;
    localparam logic [31:0] RESET_LOW   = 32'd51200;
    localparam logic [31:0] RESET_HIGH  = 32'd102400;

    // floor(x / 100) == (x * ACK_MAGIC) >> ACK_SHIFT for every 32-bit x
    localparam logic [31:0] ACK_MAGIC   = 32'h51EB851F;
    localparam int unsigned ACK_SHIFT   = 37;
    localparam int unsigned ACK_QUOT_W  = 64 - ACK_SHIFT;

    // Offset < span, so the Q16 quotient needs 16 restoring steps
    localparam int unsigned DIV_STEPS   = 16;
    localparam int unsigned DIV_CNT_W   = $clog2(DIV_STEPS);

    // Front-to-back queue
    localparam int unsigned QDEPTH      = 2;
    localparam int unsigned QPTR_W      = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int unsigned QCNT_W      = $clog2(QDEPTH + 1);

    // Register indexes
    localparam logic [1:0] REG_MAX_RATE = 2'd0;
    localparam logic [1:0] REG_LOW_THR  = 2'd1;
    localparam logic [1:0] REG_HIGH_THR = 2'd2;

    // Event codes
    localparam logic [1:0] CMD_ECN      = 2'd0;
    localparam logic [1:0] CMD_ACK      = 2'd1;
    localparam logic [1:0] CMD_NACK     = 2'd2;
    localparam logic [1:0] CMD_TIMEOUT  = 2'd3;

    // Classified operation handed to the back end
    typedef enum logic [2:0] {
        OP_ECN_ZERO = 3'd0,
        OP_ECN_FULL = 3'd1,
        OP_ECN_DIV  = 3'd2,
        OP_ACK      = 3'd3,
        OP_HALVE    = 3'd4
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [31:0] offset;   // depth - low_threshold
        logic [31:0] span;     // high_threshold - low_threshold
    } item_t;

    typedef struct packed {
        logic        load;     // max_rate written: reload current rate
        logic [31:0] max_rate;
    } rate_cfg_t;

endpackage

`default_nettype wire

// File: rtl/core/crc_front.sv
`default_nettype none

module crc_front (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [1:0]        s_cmd,
    input  wire logic [31:0]       s_queue_depth,
    input  wire logic [31:0]       low_threshold,
    input  wire logic [31:0]       high_threshold,
    output logic                   push,
    output crc_pkg::item_t         push_item,
    input  wire logic              q_ready
);
    import crc_pkg::*;

    logic  front_valid_reg;
    item_t item_reg;
    item_t item_next;

    assign s_ready   = !front_valid_reg || q_ready;
    assign push      = front_valid_reg && q_ready;
    assign push_item = item_reg;

    // classify: out-of-range depths skip the divider entirely
    always_comb begin
        item_next.offset = s_queue_depth - low_threshold;
        item_next.span   = high_threshold - low_threshold;
        case (s_cmd)
            CMD_ECN: begin
                if (s_queue_depth < low_threshold) begin
                    item_next.op = OP_ECN_ZERO;
                end else if (s_queue_depth >= high_threshold) begin
                    item_next.op = OP_ECN_FULL;
                end else begin
                    item_next.op = OP_ECN_DIV;
                end
            end
            CMD_ACK:     item_next.op = OP_ACK;
            CMD_NACK:    item_next.op = OP_HALVE;
            CMD_TIMEOUT: item_next.op = OP_HALVE;
            default:     item_next.op = OP_HALVE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_valid_reg <= 1'b0;
        end else if (s_ready) begin
            front_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= item_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/crc_queue.sv
`default_nettype none

module crc_queue (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              push,
    input  wire crc_pkg::item_t    push_item,
    output logic                   q_ready,
    output logic                   q_valid,
    output crc_pkg::item_t         q_item,
    input  wire logic              pop
);
    import crc_pkg::*;

    item_t             entry_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              do_push;
    logic              do_pop;

    assign q_ready = (count_reg != QCNT_W'(QDEPTH));
    assign q_valid = (count_reg != '0);
    assign q_item  = entry_reg[rd_ptr_reg];
    assign do_push = push && q_ready;
    assign do_pop  = pop && q_valid;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        if (p == QPTR_W'(QDEPTH - 1)) begin
            return '0;
        end
        return p + QPTR_W'(1);
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (do_pop) begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + QCNT_W'(1);
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/crc_back.sv
`default_nettype none

module crc_back (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              q_valid,
    input  wire crc_pkg::item_t    q_item,
    output logic                   pop,
    input  wire crc_pkg::rate_cfg_t rate_cfg,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [31:0]            m_send_rate,
    output logic [16:0]            m_congestion_alpha
);
    import crc_pkg::*;

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_DIV   = 8'b0000_0010,
        ST_ALPHA = 8'b0000_0100,
        ST_RMUL  = 8'b0000_1000,
        ST_AMUL  = 8'b0001_0000,
        ST_ASUM  = 8'b0010_0000,
        ST_CLAMP = 8'b0100_0000,
        ST_DONE  = 8'b1000_0000
    } state_t;

    state_t                state_reg;
    logic [31:0]           rate_reg;
    logic [FP_W-1:0]       alpha_reg;
    logic [FP_W-1:0]       p_reg;
    logic [31:0]           rem_reg;
    logic [31:0]           span_reg;
    logic [DIV_CNT_W-1:0]  cnt_reg;
    logic [32:0]           sum_reg;
    logic [ACK_QUOT_W-1:0] quot_reg;

    logic                  m_valid_reg;
    logic [31:0]           m_rate_reg;
    logic [FP_W-1:0]       m_alpha_reg;

    logic [32:0]           trial;
    logic                  trial_ge;
    logic [33:0]           alpha_sum;
    logic [FP_W-1:0]       factor;
    logic [48:0]           rate_prod;
    logic [63:0]           ack_prod;
    logic                  out_free;

    assign pop                = (state_reg == ST_IDLE) && q_valid;
    assign out_free           = !m_valid_reg || m_ready;
    assign m_valid            = m_valid_reg;
    assign m_send_rate        = m_rate_reg;
    assign m_congestion_alpha = m_alpha_reg;

    // restoring divide step, one quotient bit per cycle
    assign trial    = {rem_reg, 1'b0};
    assign trial_ge = (trial >= {1'b0, span_reg});

    // alpha' = (61440*alpha + 4096*p) >> 16, 61440*alpha as shift-subtract
    assign alpha_sum = ({1'b0, alpha_reg, 16'd0} - {5'd0, alpha_reg, 12'd0})
                     + {5'd0, p_reg, 12'd0};

    assign factor    = FP_ONE - {1'b0, alpha_reg[FP_W-1:1]};
    assign rate_prod = rate_reg * factor;
    assign ack_prod  = rate_reg * ACK_MAGIC;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            rate_reg    <= RESET_MAX;
            alpha_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (rate_cfg.load) begin
                rate_reg <= rate_cfg.max_rate;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (q_valid) begin
                        p_reg <= '0;
                        case (q_item.op)
                            OP_ECN_ZERO: state_reg <= ST_ALPHA;
                            OP_ECN_FULL: begin
                                p_reg     <= FP_ONE;
                                state_reg <= ST_ALPHA;
                            end
                            OP_ECN_DIV: begin
                                rem_reg   <= q_item.offset;
                                span_reg  <= q_item.span;
                                cnt_reg   <= '0;
                                state_reg <= ST_DIV;
                            end
                            OP_ACK: state_reg <= ST_AMUL;
                            OP_HALVE: begin
                                rate_reg  <= {1'b0, rate_reg[31:1]};
                                state_reg <= ST_DONE;
                            end
                            default: state_reg <= ST_DONE;
                        endcase
                    end
                end
                ST_DIV: begin
                    rem_reg <= trial_ge ? 32'(trial - {1'b0, span_reg}) : trial[31:0];
                    p_reg   <= {p_reg[FP_W-2:0], trial_ge};
                    cnt_reg <= cnt_reg + DIV_CNT_W'(1);
                    if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1)) begin
                        state_reg <= ST_ALPHA;
                    end
                end
                ST_ALPHA: begin
                    alpha_reg <= alpha_sum[32:16];
                    state_reg <= ST_RMUL;
                end
                ST_RMUL: begin
                    sum_reg   <= rate_prod[48:16];
                    state_reg <= ST_CLAMP;
                end
                ST_AMUL: begin
                    quot_reg  <= ack_prod[63:ACK_SHIFT];
                    state_reg <= ST_ASUM;
                end
                ST_ASUM: begin
                    sum_reg   <= {1'b0, rate_reg} + 33'(quot_reg);
                    state_reg <= ST_CLAMP;
                end
                ST_CLAMP: begin
                    rate_reg  <= (sum_reg > {1'b0, rate_cfg.max_rate}) ?
                                 rate_cfg.max_rate : sum_reg[31:0];
                    state_reg <= ST_DONE;
                end
                ST_DONE: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_DONE && out_free) begin
            m_rate_reg  <= rate_reg;
            m_alpha_reg <= alpha_reg;
        end
    end

    a_alpha_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        alpha_reg <= FP_ONE)
        else $error("alpha estimate above one");

    a_clamp: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLAMP && !rate_cfg.load) |=> rate_reg <= rate_cfg.max_rate)
        else $error("clamped rate above max_rate");

    a_cfg_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (rate_cfg.load && state_reg == ST_IDLE && !q_valid)
        |=> rate_reg == $past(rate_cfg.max_rate))
        else $error("max_rate write did not load rate");

    a_pop_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |=> state_reg != ST_IDLE)
        else $error("popped item not taken up");

endmodule

`default_nettype wire

// File: rtl/core/ecn_congestion_rate_controller.sv
`default_nettype none

// ECN congestion rate controller.
// Input channel (s_valid/s_ready): one congestion event per transfer,
// s_cmd 0 ECN (uses s_queue_depth), 1 ACK, 2 NACK, 3 timeout.
// Result channel (m_valid/m_ready): one transfer per event carrying the
// send rate after the event and the alpha estimate in Q1.16.
// Config port: cfg_we/cfg_index/cfg_wdata, index 0 max_rate (also loads
// the rate), 1 low threshold, 2 high threshold; other indexes ignored.
// Write only while no event is in flight.
// NACK/timeout go straight to the result; ACK and ECN outside the
// thresholds pass through the multiply and clamp states, and ECN
// between them first runs the restoring division in the back end
// sequencer. The back end handles one event at a time and pops the next
// only after handing the last result to the output register; the front
// register and the queue hold further events meanwhile.
// Reset (aresetn low, synchronous) restores rate 100000000, alpha 0 and
// the default thresholds, and empties the queue.
// A stalled receiver holds the result in the output register; the back
// end then waits with the next result and the queue and front register
// fill before s_ready drops.
module ecn_congestion_rate_controller (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_cmd,
    input  wire logic [31:0] s_queue_depth,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [31:0]      m_send_rate,
    output logic [16:0]      m_congestion_alpha,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_wdata
);
    import crc_pkg::*;

    logic [31:0] max_rate_reg;
    logic [31:0] low_thr_reg;
    logic [31:0] high_thr_reg;

    logic        push;
    item_t       push_item;
    logic        q_ready;
    logic        q_valid;
    item_t       q_item;
    logic        pop;
    rate_cfg_t   rate_cfg;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_rate_reg <= RESET_MAX;
            low_thr_reg  <= RESET_LOW;
            high_thr_reg <= RESET_HIGH;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_MAX_RATE: max_rate_reg <= cfg_wdata;
                REG_LOW_THR:  low_thr_reg  <= cfg_wdata;
                REG_HIGH_THR: high_thr_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // max_rate write also reloads the rate in the back end
    assign rate_cfg.load     = cfg_we && (cfg_index == REG_MAX_RATE);
    assign rate_cfg.max_rate = rate_cfg.load ? cfg_wdata : max_rate_reg;

    crc_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_cmd          (s_cmd),
        .s_queue_depth  (s_queue_depth),
        .low_threshold  (low_thr_reg),
        .high_threshold (high_thr_reg),
        .push           (push),
        .push_item      (push_item),
        .q_ready        (q_ready)
    );

    crc_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .q_ready   (q_ready),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .pop       (pop)
    );

    crc_back u_back (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .q_valid            (q_valid),
        .q_item             (q_item),
        .pop                (pop),
        .rate_cfg           (rate_cfg),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_send_rate        (m_send_rate),
        .m_congestion_alpha (m_congestion_alpha)
    );

endmodule

`default_nettype wire
